### rtl/esd_pkg.sv
// ============================================================================
// esd_pkg
// Shared types and constants for the escaped sample deframer: control
// bytes, sample kind codes, register indexes and the result record.
// ============================================================================
package esd_pkg;

    // Control bytes of the byte-stuffed stream
    localparam logic [7:0] ESC_BYTE  = 8'h66;
    localparam logic [7:0] CMD_START = 8'h01;
    localparam logic [7:0] CMD_STOP  = 8'h02;

    // Sample kind codes
    localparam logic [2:0] KIND_BYTE  = 3'd0;
    localparam logic [2:0] KIND_WORD  = 3'd1;
    localparam logic [2:0] KIND_DWORD = 3'd2;
    localparam logic [2:0] KIND_FLT32 = 3'd3;
    localparam logic [2:0] KIND_FLT64 = 3'd4;

    // Register indexes
    localparam logic REG_SAMPLE_TYPE = 1'b0;
    localparam logic REG_HOLD        = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [63:0] bits;
        logic [2:0]  kind;
    } t_result;

    // Sample size in bytes; zero for unused kinds
    function automatic logic [3:0] sample_size(input logic [2:0] kind);
        logic [3:0] size;
        unique case (kind)
            KIND_BYTE:  size = 4'd1;
            KIND_WORD:  size = 4'd2;
            KIND_DWORD: size = 4'd4;
            KIND_FLT32: size = 4'd4;
            KIND_FLT64: size = 4'd8;
            default:    size = 4'd0;
        endcase
        return size;
    endfunction

endpackage

### rtl/esd_core.sv
// ============================================================================
// esd_core
// Deframer state: escape decode, capture flag, byte count and the sample
// assembly word. Produces at most one completed sample per transaction.
// ============================================================================
module esd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_rx_byte,
    input  logic [2:0]       i_sample_type,
    input  logic             i_hold,
    input  logic             i_type_wr,
    output esd_pkg::t_result o_result
);
    import esd_pkg::*;

    logic        r_esc;
    logic        r_capt;
    logic [2:0]  r_count;
    logic [63:0] r_word;

    logic        n_esc;
    logic        n_capt;
    logic [2:0]  n_count;
    logic [63:0] n_word;

    logic [3:0]  size;
    logic        is_data;
    logic        take_data;
    logic        done;
    logic [63:0] ins_word;
    logic [63:0] keep_mask;

    assign size = sample_size(i_sample_type);

    // Classify the byte: plain data, or a literal escape after an escape
    always_comb begin
        if (r_esc) begin
            is_data = (i_rx_byte == ESC_BYTE);
        end else begin
            is_data = (i_rx_byte != ESC_BYTE);
        end
    end

    assign take_data = i_take && is_data && r_capt && (size != 4'd0);
    assign done      = ({1'b0, r_count} + 4'd1) >= size;

    // Insert the byte into its lane and build the size mask
    always_comb begin
        ins_word  = r_word;
        keep_mask = '0;
        for (int k = 0; k < 8; k++) begin
            if (r_count == 3'(k)) begin
                ins_word[8*k +: 8] = i_rx_byte;
            end
            if (4'(k) < size) begin
                keep_mask[8*k +: 8] = 8'hFF;
            end
        end
    end

    // Next-state logic
    always_comb begin
        n_esc   = r_esc;
        n_capt  = r_capt;
        n_count = r_count;
        n_word  = r_word;
        if (i_type_wr) begin
            n_capt  = 1'b0;
            n_count = '0;
        end else if (i_take) begin
            if (r_esc) begin
                n_esc = 1'b0;
                if (i_rx_byte == CMD_START) begin
                    n_capt  = 1'b1;
                    n_count = '0;
                end else if (i_rx_byte == CMD_STOP) begin
                    n_capt  = 1'b0;
                    n_count = '0;
                end
            end else if (i_rx_byte == ESC_BYTE) begin
                n_esc = 1'b1;
            end
            if (take_data) begin
                n_word  = ins_word;
                n_count = done ? 3'd0 : r_count + 3'd1;
            end
        end
    end

    // Result of this transaction
    always_comb begin
        o_result.valid = take_data && done && !i_hold;
        o_result.bits  = ins_word & keep_mask;
        o_result.kind  = i_sample_type;
    end

    // Hold control state, advance on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc   <= 1'b0;
            r_capt  <= 1'b0;
            r_count <= '0;
        end else begin
            r_esc   <= n_esc;
            r_capt  <= n_capt;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    // Type write always leaves capture off and the count cleared
    a_type_wr_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_type_wr |=> (!r_capt && r_count == 3'd0))
        else $error("type write did not clear capture state");

    // Count never reaches the sample size of a legal kind
    a_count_below_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (size != 4'd0) |-> ({1'b0, r_count} < size))
        else $error("byte count out of range for sample kind");

    // A sample is produced only while capturing
    a_result_needs_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (r_capt && i_take))
        else $error("sample emitted outside capture");

endmodule

### rtl/esd_out_reg.sv
// ============================================================================
// esd_out_reg
// Result register between the deframer and the output channel. Loads a new
// sample while empty or while the previous one is being taken.
// ============================================================================
module esd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  esd_pkg::t_result i_result,
    input  logic             i_out_ready,
    output logic             o_space,
    output logic             o_out_valid,
    output logic [63:0]      o_sample_bits,
    output logic [2:0]       o_sample_kind
);
    import esd_pkg::*;

    logic        r_valid;
    logic [63:0] r_bits;
    logic [2:0]  r_kind;

    assign o_space = !r_valid || i_out_ready;

    // Valid flag: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && i_result.valid) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load && i_result.valid) begin
            r_bits <= i_result.bits;
            r_kind <= i_result.kind;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_sample_bits = r_bits;
    assign o_sample_kind = r_kind;

    // Only legal kinds leave the block
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_kind <= KIND_FLT64))
        else $error("illegal sample kind on output");

endmodule

### rtl/escaped_sample_deframer.sv
// ============================================================================
// escaped_sample_deframer
// Byte-stuffed serial deframer: decodes escapes and start/stop commands and
// assembles captured bytes into little-endian samples of 1, 2, 4 or 8 bytes.
// ============================================================================
// A completing byte shows its sample on the output in the cycle after its
// transaction. Throughput: one byte per cycle, limited only by the
// single output register draining. Reset (synchronous, active low) clears
// the escape, capture and count state, the sample assembly word and both
// registers.
module escaped_sample_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_sample_bits,
    output logic [2:0]  o_sample_kind,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import esd_pkg::*;

    logic [2:0] r_type;
    logic       r_hold;
    logic       wr_en;
    logic       type_wr;
    logic       take;
    logic       space;
    t_result    result;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign type_wr = wr_en && (paddr[2] == REG_SAMPLE_TYPE);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type <= KIND_BYTE;
            r_hold <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_SAMPLE_TYPE: r_type <= pwdata[2:0];
                REG_HOLD:        r_hold <= pwdata[0];
                default:         r_hold <= r_hold;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (paddr[2])
            REG_SAMPLE_TYPE: prdata = {29'd0, r_type};
            REG_HOLD:        prdata = {31'd0, r_hold};
            default:         prdata = '0;
        endcase
    end

    assign o_in_ready = space;
    assign take       = i_in_valid && space;

    esd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_rx_byte     (i_rx_byte),
        .i_sample_type (r_type),
        .i_hold        (r_hold),
        .i_type_wr     (type_wr),
        .o_result      (result)
    );

    esd_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (take),
        .i_result      (result),
        .i_out_ready   (i_out_ready),
        .o_space       (space),
        .o_out_valid   (o_out_valid),
        .o_sample_bits (o_sample_bits),
        .o_sample_kind (o_sample_kind)
    );

endmodule
